[src/chess_fen_stream_parser_core_defines.svh]
// Assertion macros used by the position record parser's decode core module.
`ifndef CHESS_FEN_STREAM_PARSER_CORE_DEFINES_SVH
`define CHESS_FEN_STREAM_PARSER_CORE_DEFINES_SVH

// Check a property outside reset.
`define CFSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define CFSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[src/cfsp_pkg.sv]
// Types, codes and helper functions of the position record parser.
package cfsp_pkg;

  // Field phases of the record
  localparam logic [3:0] PH_PLACE   = 4'd0;
  localparam logic [3:0] PH_SIDE    = 4'd1;
  localparam logic [3:0] PH_SIDE_SP = 4'd2;
  localparam logic [3:0] PH_CASTLE  = 4'd3;
  localparam logic [3:0] PH_EP      = 4'd4;
  localparam logic [3:0] PH_EP_RANK = 4'd5;
  localparam logic [3:0] PH_HALF    = 4'd6;
  localparam logic [3:0] PH_MOVE    = 4'd7;
  localparam logic [3:0] PH_TAIL    = 4'd8;
  localparam logic [3:0] PH_ERR     = 4'd9;

  // Result event codes
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_PLACE = 2'd1;
  localparam logic [1:0] EV_DONE  = 2'd2;
  localparam logic [1:0] EV_ERROR = 2'd3;

  // Piece kinds
  localparam logic [2:0] KIND_PAWN   = 3'd0;
  localparam logic [2:0] KIND_KNIGHT = 3'd1;
  localparam logic [2:0] KIND_BISHOP = 3'd2;
  localparam logic [2:0] KIND_ROOK   = 3'd3;
  localparam logic [2:0] KIND_QUEEN  = 3'd4;
  localparam logic [2:0] KIND_KING   = 3'd5;
  localparam logic [2:0] KIND_NONE   = 3'd6;

  localparam logic [4:0]  BLACK_OFFSET = 5'd16;
  localparam logic [4:0]  MAX_COUNT    = 5'd15;
  localparam logic [15:0] SAT_MAX      = 16'hFFFF;

  // Characters of interest
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_ONE   = "1";
  localparam logic [7:0] CH_EIGHT = "8";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_LO_A  = "a";
  localparam logic [7:0] CH_LO_H  = "h";
  localparam logic [7:0] CH_LO_Z  = "z";
  localparam logic [7:0] CH_UP_A  = "A";
  localparam logic [7:0] CH_UP_Z  = "Z";
  localparam logic [7:0] CH_LO_P  = "p";
  localparam logic [7:0] CH_LO_N  = "n";
  localparam logic [7:0] CH_LO_B  = "b";
  localparam logic [7:0] CH_LO_R  = "r";
  localparam logic [7:0] CH_LO_Q  = "q";
  localparam logic [7:0] CH_LO_K  = "k";
  localparam logic [7:0] CH_LO_W  = "w";
  localparam logic [7:0] CH_UP_K  = "K";
  localparam logic [7:0] CH_UP_Q  = "Q";
  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_DASH  = "-";
  localparam logic [7:0] CASE_GAP = 8'd32;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } cfsp_char_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [4:0]  piece_slot;
    logic [2:0]  piece_kind;
    logic        piece_is_black;
    logic [2:0]  square_column;
    logic [2:0]  square_row;
    logic        black_to_move;
    logic [3:0]  castle_flags;
    logic        passant_valid;
    logic [2:0]  passant_file;
    logic [15:0] halfmove_count;
    logic [15:0] move_count;
  } cfsp_result_t;

  typedef struct packed {
    logic       black;
    logic [2:0] kind;
  } cfsp_piece_t;

  // Map a letter to its piece kind and colour; non-pieces give KIND_NONE
  function automatic cfsp_piece_t piece_of(input logic [7:0] c);
    cfsp_piece_t p;
    logic [7:0]  lc;
    lc      = c;
    p.black = 1'b0;
    if (c >= CH_LO_A && c <= CH_LO_Z) begin
      p.black = 1'b1;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      lc = c + CASE_GAP;
    end
    case (lc)
      CH_LO_P: p.kind = KIND_PAWN;
      CH_LO_N: p.kind = KIND_KNIGHT;
      CH_LO_B: p.kind = KIND_BISHOP;
      CH_LO_R: p.kind = KIND_ROOK;
      CH_LO_Q: p.kind = KIND_QUEEN;
      CH_LO_K: p.kind = KIND_KING;
      default: p.kind = KIND_NONE;
    endcase
    return p;
  endfunction

  // Append one decimal digit, saturating at the top of 16 bits
  function automatic logic [15:0] sat_accum(input logic [15:0] acc, input logic [7:0] c);
    logic [19:0] v;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {16'b0, c[3:0]};
    return (v > {4'b0, SAT_MAX}) ? SAT_MAX : v[15:0];
  endfunction

endpackage

[src/cfsp_if.sv]
// Stream channels of the parser: characters in, events out.
interface cfsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface cfsp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [4:0]  piece_slot;
  logic [2:0]  piece_kind;
  logic        piece_is_black;
  logic [2:0]  square_column;
  logic [2:0]  square_row;
  logic        black_to_move;
  logic [3:0]  castle_flags;
  logic        passant_valid;
  logic [2:0]  passant_file;
  logic [15:0] halfmove_count;
  logic [15:0] move_count;

  modport source (
    output valid, output event_res, output piece_slot, output piece_kind,
    output piece_is_black, output square_column, output square_row,
    output black_to_move, output castle_flags, output passant_valid,
    output passant_file, output halfmove_count, output move_count,
    input ready
  );
  modport sink (
    input valid, input event_res, input piece_slot, input piece_kind,
    input piece_is_black, input square_column, input square_row,
    input black_to_move, input castle_flags, input passant_valid,
    input passant_file, input halfmove_count, input move_count,
    output ready
  );
endinterface

[src/cfsp_input_stage.sv]
// Input register: captures one character item and holds it until it is parsed.
module cfsp_input_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  cfsp_in_if.sink             text_i,
  input  logic                advance_i,
  output logic                valid_o,
  output cfsp_pkg::cfsp_char_t char_o
);
  import cfsp_pkg::*;

  logic       valid_q;
  cfsp_char_t char_q;

  // Take a new item when empty or when the held one moves on
  assign text_i.ready = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (text_i.ready) begin
      valid_q <= text_i.valid;
    end
  end

  // Capture payload
  always_ff @(posedge clk_i) begin
    if (text_i.valid && text_i.ready) begin
      char_q.text_byte   <= text_i.text_byte;
      char_q.end_of_text <= text_i.end_of_text;
    end
  end

  assign valid_o = valid_q;
  assign char_o  = char_q;
endmodule

[src/cfsp_parse_core.sv]
// Parser state and the per-character decode that forms one result.
module cfsp_parse_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  cfsp_pkg::cfsp_char_t  char_i,
  output cfsp_pkg::cfsp_result_t result_o
);
  import cfsp_pkg::*;
  `include "chess_fen_stream_parser_core_defines.svh"

  logic [3:0]  phase_q, phase_d;
  logic [3:0]  column_q, column_d;
  logic [2:0]  row_q, row_d;
  logic [4:0]  white_count_q, white_count_d;
  logic [4:0]  black_count_q, black_count_d;
  logic        side_q, side_d;
  logic [3:0]  castle_q, castle_d;
  logic [3:0]  passant_q, passant_d;
  logic [15:0] half_q, half_d;
  logic [15:0] move_q, move_d;
  logic [1:0]  digits_q, digits_d;

  cfsp_piece_t  pc;
  cfsp_result_t res;
  logic [7:0]   c;
  logic [4:0]   skip_col;
  logic         is_digit;

  assign c        = char_i.text_byte;
  assign pc       = piece_of(c);
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign skip_col = {1'b0, column_q} + {1'b0, c[3:0]};

  // Decode one character against the current field phase
  always_comb begin
    phase_d       = phase_q;
    column_d      = column_q;
    row_d         = row_q;
    white_count_d = white_count_q;
    black_count_d = black_count_q;
    side_d        = side_q;
    castle_d      = castle_q;
    passant_d     = passant_q;
    half_d        = half_q;
    move_d        = move_q;
    digits_d      = digits_q;
    res           = '0;

    unique case (phase_q)
      PH_PLACE: begin
        if (pc.kind != KIND_NONE) begin
          if (column_q > 4'd7) begin
            phase_d = PH_ERR;
          end else if (pc.kind != KIND_KING && pc.black && black_count_q > MAX_COUNT) begin
            phase_d = PH_ERR;
          end else if (pc.kind != KIND_KING && !pc.black && white_count_q > MAX_COUNT) begin
            phase_d = PH_ERR;
          end else begin
            res.event_res      = EV_PLACE;
            res.piece_kind     = pc.kind;
            res.piece_is_black = pc.black;
            res.square_column  = column_q[2:0];
            res.square_row     = row_q;
            column_d           = column_q + 4'd1;
            if (pc.kind == KIND_KING) begin
              res.piece_slot = pc.black ? BLACK_OFFSET : 5'd0;
            end else if (pc.black) begin
              res.piece_slot = BLACK_OFFSET + black_count_q;
              black_count_d  = black_count_q + 5'd1;
            end else begin
              res.piece_slot = white_count_q;
              white_count_d  = white_count_q + 5'd1;
            end
          end
        end else if (c >= CH_ONE && c <= CH_EIGHT) begin
          if (skip_col > 5'd8) begin
            phase_d = PH_ERR;
          end else begin
            column_d = skip_col[3:0];
          end
        end else if (c == CH_SLASH) begin
          if (row_q == 3'd7) begin
            phase_d = PH_ERR;
          end else begin
            row_d    = row_q + 3'd1;
            column_d = 4'd0;
          end
        end else if (c == CH_SPACE) begin
          phase_d = PH_SIDE;
        end else begin
          phase_d = PH_ERR;
        end
      end
      PH_SIDE: begin
        if (c == CH_LO_W) begin
          side_d  = 1'b0;
          phase_d = PH_SIDE_SP;
        end else if (c == CH_LO_B) begin
          side_d  = 1'b1;
          phase_d = PH_SIDE_SP;
        end else begin
          phase_d = PH_ERR;
        end
      end
      PH_SIDE_SP: phase_d = (c == CH_SPACE) ? PH_CASTLE : PH_ERR;
      PH_CASTLE: begin
        if (c == CH_UP_K) castle_d = castle_q | 4'b0001;
        else if (c == CH_UP_Q) castle_d = castle_q | 4'b0010;
        else if (c == CH_LO_K) castle_d = castle_q | 4'b0100;
        else if (c == CH_LO_Q) castle_d = castle_q | 4'b1000;
        else if (c == CH_SPACE) phase_d = PH_EP;
        else if (c != CH_DASH) phase_d = PH_ERR;
      end
      PH_EP: begin
        if (c >= CH_LO_A && c <= CH_LO_H) begin
          passant_d = {1'b1, c[2:0] - CH_LO_A[2:0]};
          phase_d   = PH_EP_RANK;
        end else if (c == CH_SPACE) begin
          phase_d = PH_HALF;
        end else if (c != CH_DASH) begin
          phase_d = PH_ERR;
        end
      end
      PH_EP_RANK: phase_d = (c >= CH_ONE && c <= CH_EIGHT) ? PH_EP : PH_ERR;
      PH_HALF: begin
        if (is_digit) begin
          half_d      = sat_accum(half_q, c);
          digits_d[0] = 1'b1;
        end else if (c == CH_SPACE) begin
          phase_d = PH_MOVE;
        end else begin
          phase_d = PH_ERR;
        end
      end
      PH_MOVE: begin
        if (is_digit) begin
          move_d      = sat_accum(move_q, c);
          digits_d[1] = 1'b1;
        end else if (c == CH_SPACE) begin
          phase_d = PH_TAIL;
        end else begin
          phase_d = PH_ERR;
        end
      end
      PH_TAIL: phase_d = PH_TAIL;
      default: phase_d = PH_ERR;
    endcase

    // Report the record on its last character and return to reset state
    if (char_i.end_of_text) begin
      res = '0;
      if ((phase_d == PH_MOVE || phase_d == PH_TAIL) && digits_d == 2'b11) begin
        res.event_res      = EV_DONE;
        res.black_to_move  = side_d;
        res.castle_flags   = castle_d;
        res.passant_valid  = passant_d[3];
        res.passant_file   = passant_d[2:0];
        res.halfmove_count = half_d;
        res.move_count     = move_d;
      end else begin
        res.event_res = EV_ERROR;
      end
      phase_d       = PH_PLACE;
      column_d      = 4'd0;
      row_d         = 3'd0;
      white_count_d = 5'd1;
      black_count_d = 5'd1;
      side_d        = 1'b0;
      castle_d      = 4'd0;
      passant_d     = 4'd0;
      half_d        = 16'd0;
      move_d        = 16'd0;
      digits_d      = 2'd0;
    end
  end

  // Advance state when the held item moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_PLACE;
      column_q      <= 4'd0;
      row_q         <= 3'd0;
      white_count_q <= 5'd1;
      black_count_q <= 5'd1;
      side_q        <= 1'b0;
      castle_q      <= 4'd0;
      passant_q     <= 4'd0;
      half_q        <= 16'd0;
      move_q        <= 16'd0;
      digits_q      <= 2'd0;
    end else if (advance_i) begin
      phase_q       <= phase_d;
      column_q      <= column_d;
      row_q         <= row_d;
      white_count_q <= white_count_d;
      black_count_q <= black_count_d;
      side_q        <= side_d;
      castle_q      <= castle_d;
      passant_q     <= passant_d;
      half_q        <= half_d;
      move_q        <= move_d;
      digits_q      <= digits_d;
    end
  end

  assign result_o = res;

  `CFSP_ASSERT_ALWAYS(a_reset_phase, !rst_ni |=> (phase_q == PH_PLACE),
                      "phase not cleared in reset")
  `CFSP_ASSERT(a_end_restart, (advance_i && char_i.end_of_text) |=>
               (phase_q == PH_PLACE && white_count_q == 5'd1 && black_count_q == 5'd1),
               "state not restarted after record end")
  `CFSP_ASSERT(a_place_steps_col, (advance_i && res.event_res == EV_PLACE) |=>
               (column_q == $past(column_q) + 4'd1), "column did not step after placement")
  `CFSP_ASSERT(a_error_silent, (phase_q == PH_ERR && !char_i.end_of_text) |->
               (res.event_res == EV_NONE), "event emitted while in error")
endmodule

[src/cfsp_result_stage.sv]
// Result register: holds one result item until the receiver takes it.
module cfsp_result_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  cfsp_pkg::cfsp_result_t result_i,
  output logic                   space_o,
  cfsp_out_if.source             event_o
);
  import cfsp_pkg::*;

  logic         valid_q;
  cfsp_result_t res_q;

  // Room for a new result when empty or when the held one is taken
  assign space_o = !valid_q || event_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= load_i;
    end
  end

  // Capture payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign event_o.valid          = valid_q;
  assign event_o.event_res      = res_q.event_res;
  assign event_o.piece_slot     = res_q.piece_slot;
  assign event_o.piece_kind     = res_q.piece_kind;
  assign event_o.piece_is_black = res_q.piece_is_black;
  assign event_o.square_column  = res_q.square_column;
  assign event_o.square_row     = res_q.square_row;
  assign event_o.black_to_move  = res_q.black_to_move;
  assign event_o.castle_flags   = res_q.castle_flags;
  assign event_o.passant_valid  = res_q.passant_valid;
  assign event_o.passant_file   = res_q.passant_file;
  assign event_o.halfmove_count = res_q.halfmove_count;
  assign event_o.move_count     = res_q.move_count;
endmodule

[src/chess_fen_stream_parser_core.sv]
// Top level of the streaming chess position record parser.
// Usage:
//   text_i carries one character item of a position record per handshake,
//   with end_of_text high on the final character. event_o carries one
//   result item for every character item: nothing, a piece placement, a
//   completed record or an error (the last two only on end_of_text).
//   Items move on at each rising edge where valid and ready are both high.
// Path: a taken character is held in the input register, decoded, and its
//   result is then held in the result register and offered on event_o.
// Throughput: one item per cycle while the receiver keeps ready high, set by
//   the single decode step between the input register and the result register.
// Reset: rst_ni low clears both registers' valid flags and puts the parser
//   back at the start of the placement field with fresh piece counts.
//   After each end_of_text item the parser also returns to that state.
// Stall: while the receiver holds ready low the result register keeps its
//   item, the input register keeps one more, and then text_i.ready drops.
//   Board clearing between records is up to the receiver.
module chess_fen_stream_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  cfsp_in_if.sink     text_i,
  cfsp_out_if.source  event_o
);
  import cfsp_pkg::*;

  logic         char_valid;
  cfsp_char_t   char_q;
  cfsp_result_t result;
  logic         space;
  logic         advance;

  // Move the held character on when the result register has room
  assign advance = char_valid && space;

  cfsp_input_stage u_input (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .text_i   (text_i),
    .advance_i(advance),
    .valid_o  (char_valid),
    .char_o   (char_q)
  );

  cfsp_parse_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(advance),
    .char_i   (char_q),
    .result_o (result)
  );

  cfsp_result_stage u_result (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance),
    .result_i(result),
    .space_o (space),
    .event_o (event_o)
  );
endmodule
